// ===== sv/lkt_pkg.sv =====
package lkt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_BITS_DEF    = 32;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned OCC_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
  } lkt_status_t;

endpackage

// ===== sv/lru_key_tracker.sv =====
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               key
// config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (capacity)
// result    out        result_valid_o            hit_o, evicted_o, evicted_key_o, occupancy_o
//
// A key taken at one edge is registered and looked up against every held entry
// at once; its result is registered at the next edge and shown for one cycle.
// One key is taken every cycle; busy stays low and the lookup plus the
// recency shift finish within the cycle after the key register.
// Reset empties the store and sets the capacity to four; writing the capacity
// also empties the store. The receiver cannot stall the result.
module lru_key_tracker #(
  parameter int unsigned MaxEntries = lkt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KeyBits    = lkt_pkg::KEY_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [lkt_pkg::KEY_W-1:0] key_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkt_pkg::CAP_W-1:0] cfg_data_i,
  output logic                      result_valid_o,
  output logic                      hit_o,
  output logic                      evicted_o,
  output logic [lkt_pkg::KEY_W-1:0] evicted_key_o,
  output logic [lkt_pkg::OCC_W-1:0] occupancy_o
);

  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned EffW = (CntW > lkt_pkg::CAP_W) ? CntW : lkt_pkg::CAP_W;

  logic                      valid_q;
  logic [lkt_pkg::KEY_W-1:0] key_q;
  logic [lkt_pkg::CAP_W-1:0] cap_q;
  logic                      out_valid_q;
  lkt_pkg::lkt_status_t      res_q;
  lkt_pkg::lkt_status_t      status;
  logic                      cfg_write;
  logic [EffW-1:0]           cap_ext;
  logic [CntW-1:0]           cap_eff;
  logic [63:0]               key_ext;
  logic [KeyBits-1:0]        tag;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  assign cap_ext = EffW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (cap_ext > EffW'(MaxEntries)) begin
      cap_eff = CntW'(MaxEntries);
    end else begin
      cap_eff = CntW'(cap_ext);
    end
  end

  assign key_ext = 64'(key_q);
  assign tag     = key_ext[KeyBits-1:0];

  lkt_stack #(
    .MaxEntries(MaxEntries),
    .KeyBits   (KeyBits)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_write),
    .step_i  (valid_q),
    .tag_i   (tag),
    .cap_i   (cap_eff),
    .status_o(status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= lkt_pkg::CAP_RESET;
    end else begin
      valid_q     <= start && !busy;
      out_valid_q <= valid_q;
      if (cfg_write) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      key_q <= key_i;
    end
    if (valid_q) begin
      res_q <= status;
    end
  end

  assign result_valid_o = out_valid_q;
  assign hit_o          = res_q.hit;
  assign evicted_o      = res_q.evicted;
  assign evicted_key_o  = res_q.evicted_key;
  assign occupancy_o    = res_q.occupancy;

`ifndef SYNTHESIS
  a_result_follows_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past(valid_q))
    else $error("result without a registered key");

  a_cap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_eff != '0 && EffW'(cap_eff) <= EffW'(MaxEntries))
    else $error("effective capacity out of range");

  a_evict_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.evicted |-> res_q.evicted_key == '0)
    else $error("evicted key set without an eviction");
`endif

endmodule

// ===== sv/lkt_stack.sv =====
module lkt_stack #(
  parameter int unsigned MaxEntries = lkt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned KeyBits    = lkt_pkg::KEY_BITS_DEF,
  localparam int unsigned CntW      = $clog2(MaxEntries + 1),
  localparam int unsigned IdxW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                step_i,
  input  logic [KeyBits-1:0]  tag_i,
  input  logic [CntW-1:0]     cap_i,
  output lkt_pkg::lkt_status_t status_o
);

  logic [KeyBits-1:0]    stack_q [MaxEntries];
  logic [CntW-1:0]       held_q;
  logic [CntW-1:0]       held_d;
  logic [CntW-1:0]       held_step;
  logic [CntW-1:0]       cap_m1;
  logic [CntW-1:0]       limit;
  logic [MaxEntries-1:0] match;
  logic [MaxEntries-1:0] seen;
  logic [MaxEntries-1:0] shift;
  logic                  hit;
  logic                  evict;
  logic [KeyBits-1:0]    ev_tag;
  logic [63:0]           ev_ext;

  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      match[i] = (CntW'(i) < held_q) && (stack_q[i] == tag_i);
    end
    for (int j = 0; j < MaxEntries; j++) begin
      seen[j] = 1'b0;
      for (int i = 0; i < j; i++) begin
        seen[j] = seen[j] | match[i];
      end
    end
  end

  assign hit    = |match;
  assign evict  = !hit && (held_q >= cap_i);
  assign cap_m1 = cap_i - 1'b1;
  assign limit  = evict ? cap_m1 : held_q;
  assign ev_tag = stack_q[cap_m1[IdxW-1:0]];
  assign ev_ext = 64'(ev_tag);

  always_comb begin
    for (int j = 0; j < MaxEntries; j++) begin
      shift[j] = hit ? !seen[j] : (CntW'(j) <= limit);
    end
  end

  always_comb begin
    if (hit) begin
      held_step = held_q;
    end else if (evict) begin
      held_step = cap_i;
    end else begin
      held_step = held_q + 1'b1;
    end
  end

  always_comb begin
    if (clear_i) begin
      held_d = '0;
    end else if (step_i) begin
      held_d = held_step;
    end else begin
      held_d = held_q;
    end
  end

  always_comb begin
    status_o.hit         = hit;
    status_o.evicted     = evict;
    status_o.evicted_key = evict ? ev_ext[lkt_pkg::KEY_W-1:0] : '0;
    status_o.occupancy   = lkt_pkg::OCC_W'(held_step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      stack_q[0] <= tag_i;
      for (int j = 1; j < MaxEntries; j++) begin
        if (shift[j]) begin
          stack_q[j] <= stack_q[j-1];
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_held_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_i)
    else $error("held count exceeds capacity");

  a_hit_evict_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> !(hit && evict))
    else $error("hit and eviction together");

  a_hit_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && hit && !clear_i |=> $stable(held_q))
    else $error("hit changed the held count");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !hit && !evict && !clear_i |=> held_q == $past(held_q) + 1'b1)
    else $error("miss with room did not grow the held count");
`endif

endmodule
